### hdl/birm_pkg.sv
// Package for the bound-pointer register machine.
// Holds the item types, command and opcode codes and the register indexes.
// No dependencies; used by the top level and its checker.
package birm_pkg;

  // Number of architectural registers.
  localparam int NREGS = 6;

  // Command codes of an input item.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POINTER_REG = 2'd0;
  localparam logic [1:0] CFG_START_VALUE = 2'd1;
  localparam logic [1:0] CFG_PROGRAM_LEN = 2'd2;

  typedef enum logic [3:0] {
    OP_ADDR = 4'd0,
    OP_ADDI = 4'd1,
    OP_MULR = 4'd2,
    OP_MULI = 4'd3,
    OP_BANR = 4'd4,
    OP_BANI = 4'd5,
    OP_BORR = 4'd6,
    OP_BORI = 4'd7,
    OP_SETR = 4'd8,
    OP_SETI = 4'd9,
    OP_GTRR = 4'd10,
    OP_GTIR = 4'd11,
    OP_GTRI = 4'd12,
    OP_EQRR = 4'd13,
    OP_EQIR = 4'd14,
    OP_EQRI = 4'd15
  } op_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         load_index;
    logic [3:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [2:0]         target;
  } in_item_t;

  typedef struct packed {
    logic               halted;
    logic signed [31:0] pointer;
    logic signed [31:0] reg0;
    logic signed [31:0] reg1;
    logic signed [31:0] reg2;
    logic signed [31:0] reg3;
    logic signed [31:0] reg4;
    logic signed [31:0] reg5;
  } out_item_t;

  // One stored program instruction.
  typedef struct packed {
    op_e         opcode;
    logic [31:0] opnd_a;
    logic [31:0] opnd_b;
    logic [2:0]  target;
  } prog_word_t;

endpackage

### hdl/bound_ip_register_machine.sv
// Bound-pointer register machine with an input register and a result register.
// One item per cycle unless stalled; the pointer-to-fetch loop closes through a registered
// prefetch of program memory at the next pointer value, so every step finds its instruction.
// A stalled result holds the input register, and the input stalls once both are occupied.
// Reset (rst_ni low, asynchronous) clears both pipeline valids, sets register 0 to one, the
// other registers, pointer and halt flag to zero, and the configuration registers to one.
module bound_ip_register_machine #(
  parameter int PROGRAM_DEPTH = 64,
  parameter int DATA_WIDTH    = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  birm_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output birm_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import birm_pkg::*;

  localparam int AW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam int DW = DATA_WIDTH;

  typedef logic [DW-1:0] word_t;

  // Sign-extend (or truncate) a 32-bit immediate to the datapath width.
  function automatic word_t imm_of(input logic [31:0] raw);
    logic [63:0] ext;
    ext = {{32{raw[31]}}, raw};
    return ext[DW-1:0];
  endfunction

  // Zero-extend (or truncate) a datapath word to the 32-bit result fields.
  function automatic logic [31:0] to_out(input word_t w);
    logic [63:0] ext;
    ext = 64'(w);
    return ext[31:0];
  endfunction

  // True when the pointer addresses a loaded instruction.
  function automatic logic in_program(input word_t p, input logic [6:0] len);
    logic [63:0] lim;
    lim = (64'(len) < 64'(PROGRAM_DEPTH)) ? 64'(len) : 64'(PROGRAM_DEPTH);
    return !p[DW-1] && (64'(p) < lim);
  endfunction

  // Configuration registers.
  logic [2:0]  ptr_reg_q;
  logic [31:0] start_val_q;
  logic [6:0]  prog_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_reg_q   <= 3'd1;
      start_val_q <= 32'd1;
      prog_len_q  <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_POINTER_REG: ptr_reg_q   <= cfg_data_i[2:0];
        CFG_START_VALUE: start_val_q <= cfg_data_i;
        CFG_PROGRAM_LEN: prog_len_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Input register and the handshake around the execute step. The execute step fires
  // whenever an item waits in the input register and the result register is free or
  // being emptied in the same cycle.
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q, out_d;
  logic      out_valid_q;
  logic      exec_fire;

  assign exec_fire  = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || exec_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (exec_fire) begin
        in_valid_q <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Architectural state.
  word_t regs_q [NREGS];
  word_t regs_d [NREGS];
  word_t ip_q, ip_d;
  logic  halt_q, halt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NREGS; i++) begin
        regs_q[i] <= (i == 0) ? word_t'(1) : '0;
      end
      ip_q   <= '0;
      halt_q <= 1'b0;
    end else begin
      regs_q <= regs_d;
      ip_q   <= ip_d;
      halt_q <= halt_d;
    end
  end

  // Program memory. The read port always fetches the slot at the next pointer value, so
  // the instruction for the current pointer sits in fetch_q. A load into the slot being
  // fetched in the same cycle is forwarded.
  prog_word_t  prog_mem [PROGRAM_DEPTH];
  prog_word_t  fetch_q;
  prog_word_t  wr_word;
  logic        wr_en;
  logic [31:0] wr_idx_ext;
  logic [63:0] rd_idx_ext;
  logic [AW-1:0] wr_addr, rd_addr;

  assign wr_word.opcode = op_e'(in_q.opcode);
  assign wr_word.opnd_a = in_q.operand_a;
  assign wr_word.opnd_b = in_q.operand_b;
  assign wr_word.target = in_q.target;
  assign wr_idx_ext     = 32'(in_q.load_index);
  assign wr_addr        = wr_idx_ext[AW-1:0];
  assign rd_idx_ext     = 64'(ip_d);
  assign rd_addr        = rd_idx_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      prog_mem[wr_addr] <= wr_word;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      fetch_q <= wr_word;
    end else begin
      fetch_q <= prog_mem[rd_addr];
    end
  end

  // Execute: the bound register first takes the pointer, then operands are read.
  logic  bound;
  word_t regs_v [NREGS];
  word_t reg_a, reg_b, imm_a, imm_b, mul_rhs, product, alu_res;
  logic  tgt_ok;

  assign bound = 32'(ptr_reg_q) < 32'(NREGS);
  assign tgt_ok = 32'(fetch_q.target) < 32'(NREGS);

  always_comb begin
    regs_v = regs_q;
    if (bound) begin
      regs_v[ptr_reg_q] = ip_q;
    end
    reg_a   = (fetch_q.opnd_a < 32'(NREGS)) ? regs_v[fetch_q.opnd_a[2:0]] : '0;
    reg_b   = (fetch_q.opnd_b < 32'(NREGS)) ? regs_v[fetch_q.opnd_b[2:0]] : '0;
    imm_a   = imm_of(fetch_q.opnd_a);
    imm_b   = imm_of(fetch_q.opnd_b);
    mul_rhs = (fetch_q.opcode == OP_MULR) ? reg_b : imm_b;
    product = reg_a * mul_rhs;
    case (fetch_q.opcode)
      OP_ADDR: alu_res = reg_a + reg_b;
      OP_ADDI: alu_res = reg_a + imm_b;
      OP_MULR: alu_res = product;
      OP_MULI: alu_res = product;
      OP_BANR: alu_res = reg_a & reg_b;
      OP_BANI: alu_res = reg_a & imm_b;
      OP_BORR: alu_res = reg_a | reg_b;
      OP_BORI: alu_res = reg_a | imm_b;
      OP_SETR: alu_res = reg_a;
      OP_SETI: alu_res = imm_a;
      OP_GTRR: alu_res = word_t'($signed(reg_a) > $signed(reg_b));
      OP_GTIR: alu_res = word_t'($signed(imm_a) > $signed(reg_b));
      OP_GTRI: alu_res = word_t'($signed(reg_a) > $signed(imm_b));
      OP_EQRR: alu_res = word_t'(reg_a == reg_b);
      OP_EQIR: alu_res = word_t'(imm_a == reg_b);
      OP_EQRI: alu_res = word_t'(reg_a == imm_b);
      default: alu_res = '0;
    endcase
  end

  // Next state per command. Loads and ignored commands leave the machine state alone.
  always_comb begin
    regs_d = regs_q;
    ip_d   = ip_q;
    halt_d = halt_q;
    wr_en  = 1'b0;
    if (exec_fire) begin
      case (in_q.command)
        CMD_LOAD: begin
          wr_en = wr_idx_ext < 32'(PROGRAM_DEPTH);
        end
        CMD_START: begin
          for (int i = 0; i < NREGS; i++) begin
            regs_d[i] = '0;
          end
          regs_d[0] = imm_of(start_val_q);
          ip_d      = '0;
          halt_d    = !in_program('0, prog_len_q);
        end
        CMD_STEP: begin
          if (!halt_q) begin
            if (!in_program(ip_q, prog_len_q)) begin
              halt_d = 1'b1;
            end else begin
              regs_d = regs_v;
              if (tgt_ok) begin
                regs_d[fetch_q.target] = alu_res;
              end
              if (bound && tgt_ok && (fetch_q.target == ptr_reg_q)) begin
                ip_d = alu_res + word_t'(1);
              end else begin
                ip_d = ip_q + word_t'(1);
              end
              halt_d = !in_program(ip_d, prog_len_q);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_d.halted  = halt_d;
    out_d.pointer = to_out(ip_d);
    out_d.reg0    = to_out(regs_d[0]);
    out_d.reg1    = to_out(regs_d[1]);
    out_d.reg2    = to_out(regs_d[2]);
    out_d.reg3    = to_out(regs_d[3]);
    out_d.reg4    = to_out(regs_d[4]);
    out_d.reg5    = to_out(regs_d[5]);
  end

endmodule

### hdl/birm_checker.sv
// Port-level checker for the bound-pointer register machine, with its bind.
// Depends on birm_pkg for the result item type.
module birm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input birm_pkg::out_item_t out_item_o
);
  import birm_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("result payload changed while stalled");

  // The input side only backs up when the result side is full and stalled.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a stalled result");

  // Taking a result always frees room for a new item.
  a_ready_on_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input not ready while result drains");

  // A running machine always points inside a program of at most 4096 slots.
  a_running_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.halted |-> out_item_o.pointer[31:12] == 20'd0)
    else $error("running machine reports pointer outside program");

endmodule

bind bound_ip_register_machine birm_checker u_birm_checker (.*);

### sim/tb_bound_ip_register_machine.sv
// Self-checking testbench for the bound-pointer register machine.
// Depends on birm_pkg (hdl/birm_pkg.sv) and bound_ip_register_machine; needs no other files.
// A directed table runs first, then random programs run under several idling patterns.
module tb_bound_ip_register_machine;
  import birm_pkg::*;

  // Command code that the machine ignores; the package has no name for it.
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int PROGRAM_SLOTS = 64;
  localparam int ITEMS_PER_PHASE = 70;
  localparam int NUM_PHASES = 8;
  localparam int HOLD_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 4000;

  // Machine state right after reset, and after a start with a start value of one.
  localparam out_item_t CLEAN_STATE = '{1'b0, 32'sd0, 32'sd1, 32'sd0, 32'sd0,
                                        32'sd0, 32'sd0, 32'sd0};

  typedef struct {
    bit          is_cfg;
    in_item_t    item;
    bit          typed;
    out_item_t   want;
    logic [2:0]  ptr_sel;
    logic [31:0] start_val;
    logic [6:0]  prog_len;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_POINTER_REG;
  logic [31:0] cfg_data_i = '0;

  // Predicted machine state and configuration.
  logic [31:0] mach_regs [NREGS];
  logic [31:0] mach_ip;
  logic        mach_halted;
  prog_word_t  prog_mem [PROGRAM_SLOTS];
  bit          slot_loaded [PROGRAM_SLOTS];
  logic [2:0]  cfg_ptr_sel;
  logic [31:0] cfg_start;
  logic [6:0]  cfg_len;

  out_item_t   state_due [$];
  stim_row_t   directed_rows [$];
  int          mismatch_count = 0;
  int          items_offered = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_left = 0;
  bit          hold_request = 1'b0;
  int          quiet_cycles = 0;

  // Per-phase settings of the random part; odd phases draw a random start value.
  logic [2:0]  phase_ptr [NUM_PHASES] = '{3'd0, 3'd5, 3'd6, 3'd2, 3'd3, 3'd7, 3'd4, 3'd1};
  logic [6:0]  phase_len [NUM_PHASES] = '{7'd4, 7'd64, 7'd8, 7'd1, 7'd0, 7'd127, 7'd12, 7'd6};
  logic [31:0] phase_start [NUM_PHASES] = '{32'h0, 32'h0, 32'h7fff_ffff, 32'h0,
                                           32'hffff_ffff, 32'h0, 32'h8000_0000, 32'h0};

  bound_ip_register_machine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor of the machine.
  // ---------------------------------------------------------------------------

  // Register operands outside the register file, negative ones included, read zero.
  function automatic logic [31:0] reg_value(logic [31:0] idx);
    return (idx < NREGS) ? mach_regs[idx] : 32'd0;
  endfunction

  // The program runs while the pointer is non-negative and below the clamped length.
  function automatic bit pointer_in_program(logic [31:0] p);
    logic [31:0] eff;
    eff = (cfg_len < PROGRAM_SLOTS) ? 32'(cfg_len) : 32'(PROGRAM_SLOTS);
    return !p[31] && (p < eff);
  endfunction

  function automatic logic [31:0] alu_result(op_e op, logic [31:0] a, logic [31:0] b);
    logic [31:0] ra;
    logic [31:0] rb;
    ra = reg_value(a);
    rb = reg_value(b);
    case (op)
      OP_ADDR: return ra + rb;
      OP_ADDI: return ra + b;
      OP_MULR: return ra * rb;
      OP_MULI: return ra * b;
      OP_BANR: return ra & rb;
      OP_BANI: return ra & b;
      OP_BORR: return ra | rb;
      OP_BORI: return ra | b;
      OP_SETR: return ra;
      OP_SETI: return a;
      OP_GTRR: return {31'b0, $signed(ra) > $signed(rb)};
      OP_GTIR: return {31'b0, $signed(a) > $signed(rb)};
      OP_GTRI: return {31'b0, $signed(ra) > $signed(b)};
      OP_EQRR: return {31'b0, ra == rb};
      OP_EQIR: return {31'b0, a == rb};
      default: return {31'b0, ra == b};
    endcase
  endfunction

  // Applies one accepted item to the predicted state and returns the state it reports.
  function automatic out_item_t advance_machine(in_item_t it);
    prog_word_t  w;
    logic [31:0] res;
    bit          bound;
    out_item_t   o;
    case (it.command)
      CMD_LOAD: begin
        prog_mem[it.load_index] = '{op_e'(it.opcode), it.operand_a, it.operand_b, it.target};
        slot_loaded[it.load_index] = 1'b1;
      end
      CMD_START: begin
        foreach (mach_regs[k]) mach_regs[k] = '0;
        mach_regs[0] = cfg_start;
        mach_ip = '0;
        mach_halted = !pointer_in_program(mach_ip);
      end
      CMD_STEP: begin
        if (!mach_halted) begin
          if (!pointer_in_program(mach_ip)) begin
            // The length shrank under a running program.
            mach_halted = 1'b1;
          end else begin
            w = prog_mem[mach_ip[5:0]];
            bound = (cfg_ptr_sel < NREGS);
            if (bound) mach_regs[cfg_ptr_sel] = mach_ip;
            res = alu_result(w.opcode, w.opnd_a, w.opnd_b);
            if (w.target < NREGS) mach_regs[w.target] = res;
            if (bound) mach_ip = mach_regs[cfg_ptr_sel];
            mach_ip = mach_ip + 32'd1;
            mach_halted = !pointer_in_program(mach_ip);
          end
        end
      end
      default: ;
    endcase
    o.halted  = mach_halted;
    o.pointer = mach_ip;
    o.reg0    = mach_regs[0];
    o.reg1    = mach_regs[1];
    o.reg2    = mach_regs[2];
    o.reg3    = mach_regs[3];
    o.reg4    = mach_regs[4];
    o.reg5    = mach_regs[5];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic in_item_t make_item(logic [1:0] cmd, logic [5:0] idx, op_e op,
                                         logic [31:0] a, logic [31:0] b, logic [2:0] tgt);
    in_item_t it;
    it.command    = cmd;
    it.load_index = idx;
    it.opcode     = op;
    it.operand_a  = a;
    it.operand_b  = b;
    it.target     = tgt;
    return it;
  endfunction

  function automatic void push_row(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    directed_rows.insert(directed_rows.size(), '{1'b0, it, typed, want, 3'd0, 32'd0, 7'd0});
  endfunction

  // Operands lean toward valid register numbers but also cover out-of-range
  // indexes, small signed immediates, extremes and fully random words.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 32'($urandom_range(0, 5));
      5: return 32'($urandom_range(6, 7));
      6: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h0000_0001;
          2: return 32'hffff_ffff;
          3: return 32'h8000_0000;
          default: return 32'h7fff_ffff;
        endcase
      end
      7: return $urandom();
      8: return 32'($urandom_range(0, 6)) - 32'd3;
      default: return 32'($urandom_range(0, 63));
    endcase
  endfunction

  // Targets hit the bound register often, so that programs branch and loop.
  function automatic in_item_t random_item(logic [1:0] cmd);
    in_item_t it;
    int       r;
    r = $urandom_range(0, 9);
    it.command    = cmd;
    it.load_index = 6'($urandom_range(0, 63));
    it.opcode     = 4'($urandom_range(0, 15));
    it.operand_a  = pick_operand();
    it.operand_b  = pick_operand();
    if (r < 5) it.target = 3'($urandom_range(0, 5));
    else if (r < 8) it.target = cfg_ptr_sel;
    else it.target = 3'($urandom_range(6, 7));
    return it;
  endfunction

  // Offers one item, with random idle cycles ahead of it, and records its expected
  // result when the item is accepted. Returns at the accepting edge with valid high.
  task automatic offer_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = advance_machine(it);
    state_due.insert(state_due.size(), typed ? want : predicted);
    items_offered++;
  endtask

  // Configuration is written only with the machine drained.
  task automatic program_config(input logic [2:0] ptr, input logic [31:0] start,
                                input logic [6:0] len);
    in_valid_i <= 1'b0;
    while (state_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_POINTER_REG;
    cfg_data_i  <= {29'b0, ptr};
    @(posedge clk_i);
    cfg_index_i <= CFG_START_VALUE;
    cfg_data_i  <= start;
    @(posedge clk_i);
    cfg_index_i <= CFG_PROGRAM_LEN;
    cfg_data_i  <= {25'b0, len};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_ptr_sel = ptr;
    cfg_start   = start;
    cfg_len     = len;
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_state(input out_item_t got);
    out_item_t   want;
    logic [31:0] g [8];
    logic [31:0] w [8];
    string       names [8];
    if (state_due.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending, pointer %h", got.pointer));
      return;
    end
    want = state_due.pop_front();
    names = '{"halted", "pointer", "reg0", "reg1", "reg2", "reg3", "reg4", "reg5"};
    g = '{{31'b0, got.halted}, got.pointer, got.reg0, got.reg1, got.reg2, got.reg3,
          got.reg4, got.reg5};
    w = '{{31'b0, want.halted}, want.pointer, want.reg0, want.reg1, want.reg2, want.reg3,
          want.reg4, want.reg5};
    for (int k = 0; k < 8; k++) begin
      if (g[k] !== w[k])
        report_mismatch($sformatf("%s is %h, expected %h", names[k], g[k], w[k]));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: checks every accepted result and stalls at random. A requested
  // hold keeps ready low for a long stretch so that the machine backs up.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) check_state(out_item_o);
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Ends the run when neither channel has moved an item for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_bound_ip_register_machine NOT OK");
      $finish;
    end
  end

  initial begin
    int          eff;
    int          phase_first;
    int          steps;
    logic [31:0] start_val;
    logic [95:0] raw;
    in_item_t    it;

    // Predictor state after reset.
    foreach (mach_regs[k]) mach_regs[k] = '0;
    mach_regs[0] = 32'd1;
    mach_ip      = '0;
    mach_halted  = 1'b0;
    foreach (slot_loaded[k]) slot_loaded[k] = 1'b0;
    foreach (prog_mem[k]) prog_mem[k] = '0;
    cfg_ptr_sel = 3'd1;
    cfg_start   = 32'd1;
    cfg_len     = 7'd1;

    // Directed table. With the reset configuration only slot zero may run.
    push_row(make_item(CMD_LOAD, 6'd0, OP_SETI, 32'h7fff_ffff, 32'd0, 3'd2), 1'b1, CLEAN_STATE);
    // Command three is ignored and reports the unchanged state.
    push_row(make_item(CMD_NONE, 6'h3f, OP_EQRI, 32'hffff_ffff, 32'hffff_ffff, 3'd7),
             1'b1, CLEAN_STATE);
    push_row(make_item(CMD_LOAD, 6'd63, OP_EQRI, 32'h8000_0000, 32'hffff_ffff, 3'd7),
             1'b1, CLEAN_STATE);
    // The first step leaves the one-slot program; the second finds the machine halted.
    push_row(make_item(CMD_STEP, 6'd0, OP_ADDR, 32'd0, 32'd0, 3'd0));
    push_row(make_item(CMD_STEP, 6'd0, OP_ADDR, 32'd0, 32'd0, 3'd0));
    push_row(make_item(CMD_START, 6'd0, OP_ADDR, 32'd0, 32'd0, 3'd0), 1'b1, CLEAN_STATE);
    // Sixteen slots with register 5 bound and the most negative start value.
    directed_rows.insert(directed_rows.size(),
                         '{1'b1, '0, 1'b0, '0, 3'd5, 32'h8000_0000, 7'd16});
    push_row(make_item(CMD_LOAD, 6'd0, OP_ADDR, 32'd0, 32'd0, 3'd1));
    push_row(make_item(CMD_LOAD, 6'd1, OP_ADDI, 32'd0, 32'hffff_ffff, 3'd2));
    push_row(make_item(CMD_LOAD, 6'd2, OP_MULR, 32'd2, 32'd2, 3'd3));
    push_row(make_item(CMD_LOAD, 6'd3, OP_MULI, 32'd2, 32'h8000_0000, 3'd4));
    push_row(make_item(CMD_LOAD, 6'd4, OP_BANR, 32'd2, 32'd0, 3'd3));
    // A target above five is discarded.
    push_row(make_item(CMD_LOAD, 6'd5, OP_BANI, 32'd2, 32'hffff_ffff, 3'd6));
    // Register operands above five, negative ones included, read zero.
    push_row(make_item(CMD_LOAD, 6'd6, OP_BORR, 32'd6, 32'd0, 3'd1));
    push_row(make_item(CMD_LOAD, 6'd7, OP_BORI, 32'hffff_ffff, 32'd5, 3'd4));
    push_row(make_item(CMD_LOAD, 6'd8, OP_SETR, 32'd5, 32'd0, 3'd3));
    push_row(make_item(CMD_LOAD, 6'd9, OP_SETI, 32'hffff_ffff, 32'd0, 3'd7));
    push_row(make_item(CMD_LOAD, 6'd10, OP_GTRR, 32'd2, 32'd0, 3'd1));
    push_row(make_item(CMD_LOAD, 6'd11, OP_GTIR, 32'h8000_0000, 32'd2, 3'd2));
    push_row(make_item(CMD_LOAD, 6'd12, OP_GTRI, 32'd0, 32'h7fff_ffff, 3'd3));
    push_row(make_item(CMD_LOAD, 6'd13, OP_EQRR, 32'd4, 32'd4, 3'd4));
    push_row(make_item(CMD_LOAD, 6'd14, OP_EQIR, 32'd14, 32'd5, 3'd0));
    // Writes the bound register, so the pointer jumps back to slot two.
    push_row(make_item(CMD_LOAD, 6'd15, OP_EQRI, 32'd5, 32'd15, 3'd5));
    push_row(make_item(CMD_START, 6'd0, OP_ADDR, 32'd0, 32'd0, 3'd0));
    repeat (17) push_row(make_item(CMD_STEP, 6'd0, OP_ADDR, 32'd0, 32'd0, 3'd0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        program_config(directed_rows[i].ptr_sel, directed_rows[i].start_val,
                       directed_rows[i].prog_len);
      end else begin
        offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random part: each phase loads every runnable slot not yet loaded, then mostly runs
    // programs from a start, with some reloads and fully random items mixed in.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      start_val = (ph % 2 == 0) ? phase_start[ph] : $urandom();
      program_config(phase_ptr[ph], start_val, phase_len[ph]);
      case (ph % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 66;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct = 66;
        end
        default: begin
          tx_idle_pct = 31;
          rx_stall_pct = 31;
        end
      endcase
      eff = (phase_len[ph] < PROGRAM_SLOTS) ? int'(phase_len[ph]) : PROGRAM_SLOTS;
      phase_first = items_offered;
      // No step may ever fetch a slot that was never loaded.
      for (int s = 0; s < eff; s++) begin
        if (!slot_loaded[s] || $urandom_range(0, 1) == 1) begin
          it = random_item(CMD_LOAD);
          it.load_index = 6'(s);
          offer_item(it, 1'b0, '0);
        end
      end
      // The sender keeps offering while the result side holds off.
      if (ph % 4 == 0) hold_request = 1'b1;
      while (items_offered - phase_first < ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 99)) inside
          [0:7]: begin
            raw = {$urandom(), $urandom(), $urandom()};
            offer_item(raw[78:0], 1'b0, '0);
          end
          [8:13]: begin
            it = random_item(CMD_LOAD);
            if (eff > 0) it.load_index = 6'($urandom_range(0, eff - 1));
            offer_item(it, 1'b0, '0);
          end
          default: begin
            offer_item(random_item(CMD_START), 1'b0, '0);
            steps = $urandom_range(1, (eff > 30) ? 36 : eff + 6);
            repeat (steps) offer_item(random_item(CMD_STEP), 1'b0, '0);
          end
        endcase
      end
    end

    in_valid_i <= 1'b0;
    while (state_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_bound_ip_register_machine OK");
    end else begin
      $display("tb_bound_ip_register_machine NOT OK");
    end
    $finish;
  end

endmodule
